// ===== design/matrix_vector_product_defines.svh =====
// Assertion macros for the files that check their own logic.
`ifndef MATRIX_VECTOR_PRODUCT_DEFINES_SVH
`define MATRIX_VECTOR_PRODUCT_DEFINES_SVH

// The consequent must hold in the same cycle as the antecedent.
`define MVP_ASSERT_SAME(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define MVP_ASSERT_NEXT(label, clk, rst, ante, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== design/mvp_pkg.sv =====
`timescale 1ns / 1ps

package mvp_pkg;

   localparam int DEF_MAX_ROWS    = 16;
   localparam int DEF_MAX_COLUMNS = 16;

   localparam int ELEMENT_W   = 16;
   localparam int PRODUCT_W   = 2 * ELEMENT_W;
   localparam int SUM_W       = 36;
   localparam int ROW_INDEX_W = 4;
   localparam int CSR_DATA_W  = 5;
   localparam int CSR_INDEX_W = 2;
   // Wide enough for any count up to the largest supported maximum of 256.
   localparam int COUNT_W     = 9;
   localparam int QUEUE_DEPTH = 2;

   localparam logic [CSR_INDEX_W-1:0] CSR_ROW_COUNT    = CSR_INDEX_W'(0);
   localparam logic [CSR_INDEX_W-1:0] CSR_COLUMN_COUNT = CSR_INDEX_W'(1);

   localparam logic MODE_VECTOR = 1'b0;
   localparam logic MODE_MATRIX = 1'b1;

   localparam logic [CSR_DATA_W-1:0] RESET_ROW_COUNT    = CSR_DATA_W'(4);
   localparam logic [CSR_DATA_W-1:0] RESET_COLUMN_COUNT = CSR_DATA_W'(4);

   typedef struct packed {
      logic                        mode;
      logic signed [ELEMENT_W-1:0] element_value;
   } req_type;

   typedef struct packed {
      logic signed [SUM_W-1:0]  row_sum;
      logic [ROW_INDEX_W-1:0]   row_index;
      logic                     last_row;
   } rsp_type;

   typedef struct packed {
      logic [CSR_DATA_W-1:0] row_count;
      logic [CSR_DATA_W-1:0] column_count;
   } cfg_type;

   typedef struct packed {
      logic signed [ELEMENT_W-1:0] element_value;
      logic signed [ELEMENT_W-1:0] vector_value;
      logic                        last_column;
      logic [ROW_INDEX_W-1:0]      row_index;
      logic                        last_row;
   } work_type;

   // A count of zero acts as one, and a count above the maximum acts as the maximum.
   function automatic logic [COUNT_W-1:0] effective_count(
      input logic [CSR_DATA_W-1:0] raw,
      input logic [COUNT_W-1:0]    maximum
   );
      logic [COUNT_W-1:0] wide;
      wide = COUNT_W'(raw);
      if (raw == '0) begin
         return COUNT_W'(1);
      end else if (wide > maximum) begin
         return maximum;
      end
      return wide;
   endfunction

endpackage

// ===== design/matrix_vector_product.sv =====
`timescale 1ns / 1ps

// Dense matrix-vector product over signed Q8.8 elements. Load the vector first with mode 0
// items, then stream the matrix in row-major order with mode 1 items; after the last column
// of each row one result carries the exact Q20.16 row sum, its row index and a flag on the
// final row. The block takes one item every clock cycle when the result side keeps up, set
// by the single multiplier and accumulator in the back end. A matrix element enters the
// front stage register at the edge that accepts it, where the vector store is read, then
// passes through the two-entry queue and the multiplier register, and the accumulator sum
// loads the result register. There is no clearing pass after reset; the vector store must
// be loaded before a matrix is streamed. The user must write row and column counts through
// the register port only while no item is in flight; the block itself does not enforce it.
module matrix_vector_product #(
   parameter int MAX_ROWS    = mvp_pkg::DEF_MAX_ROWS,
   parameter int MAX_COLUMNS = mvp_pkg::DEF_MAX_COLUMNS
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_valid,
   output logic                               req_ready,
   input  mvp_pkg::req_type                   req_payload,
   output logic                               rsp_valid,
   input  logic                               rsp_ready,
   output mvp_pkg::rsp_type                   rsp_payload,
   input  logic                               csr_write_enable,
   input  logic [mvp_pkg::CSR_INDEX_W-1:0]    csr_index,
   input  logic [mvp_pkg::CSR_DATA_W-1:0]     csr_write_data
);
   import mvp_pkg::*;

`include "matrix_vector_product_defines.svh"

   cfg_type  cfg_ff;
   cfg_type  cfg_in;

   logic     q_push_valid;
   logic     q_push_ready;
   work_type q_push_data;
   logic     q_pop_valid;
   logic     q_pop_ready;
   work_type q_pop_data;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_write_enable) begin
         unique case (csr_index)
            CSR_ROW_COUNT: begin
               cfg_in.row_count = csr_write_data;
            end
            CSR_COLUMN_COUNT: begin
               cfg_in.column_count = csr_write_data;
            end
            default: begin
               cfg_in = cfg_ff;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.row_count    <= RESET_ROW_COUNT;
         cfg_ff.column_count <= RESET_COLUMN_COUNT;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   mvp_front #(
      .MAX_ROWS    (MAX_ROWS),
      .MAX_COLUMNS (MAX_COLUMNS)
   ) u_front (
      .clock       (clock),
      .reset       (reset),
      .cfg         (cfg_ff),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_payload (req_payload),
      .push_valid  (q_push_valid),
      .push_ready  (q_push_ready),
      .push_data   (q_push_data)
   );

   mvp_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (q_push_valid),
      .push_ready (q_push_ready),
      .push_data  (q_push_data),
      .pop_valid  (q_pop_valid),
      .pop_ready  (q_pop_ready),
      .pop_data   (q_pop_data)
   );

   mvp_back u_back (
      .clock       (clock),
      .reset       (reset),
      .pop_valid   (q_pop_valid),
      .pop_ready   (q_pop_ready),
      .pop_data    (q_pop_data),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_payload (rsp_payload)
   );

   `MVP_ASSERT_SAME(a_front_holds_when_queue_full, clock, reset,
      q_push_valid && !q_push_ready, !req_ready, "Front accepted an item over a waiting one.")

   `MVP_ASSERT_NEXT(a_matrix_item_reaches_front_stage, clock, reset,
      req_valid && req_ready && (req_payload.mode == MODE_MATRIX), q_push_valid,
      "Accepted matrix item did not reach the front stage.")

   `MVP_ASSERT_NEXT(a_front_stage_holds, clock, reset,
      q_push_valid && !q_push_ready, q_push_valid && $stable(q_push_data),
      "Stalled front stage changed its item.")

endmodule

// ===== design/mvp_front.sv =====
`timescale 1ns / 1ps

module mvp_front #(
   parameter int MAX_ROWS    = mvp_pkg::DEF_MAX_ROWS,
   parameter int MAX_COLUMNS = mvp_pkg::DEF_MAX_COLUMNS
) (
   input  logic              clock,
   input  logic              reset,
   input  mvp_pkg::cfg_type  cfg,
   input  logic              req_valid,
   output logic              req_ready,
   input  mvp_pkg::req_type  req_payload,
   output logic              push_valid,
   input  logic              push_ready,
   output mvp_pkg::work_type push_data
);
   import mvp_pkg::*;

   localparam int COL_W = (MAX_COLUMNS > 1) ? $clog2(MAX_COLUMNS) : 1;
   localparam int ROW_W = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;

   logic signed [ELEMENT_W-1:0] vector_store [MAX_COLUMNS];

   logic [COUNT_W-1:0] rows;
   logic [COUNT_W-1:0] cols;

   logic               fire;
   logic               load_fire;
   logic               matrix_fire;

   logic [COL_W-1:0]   load_ff;
   logic [COL_W-1:0]   load_in;
   logic [COL_W-1:0]   load_cur;
   logic [COUNT_W-1:0] load_sum;

   logic [COL_W-1:0]   col_ff;
   logic [COL_W-1:0]   col_in;
   logic [COL_W-1:0]   col_cur;
   logic [COUNT_W-1:0] col_sum;
   logic               col_last;

   logic [ROW_W-1:0]   row_ff;
   logic [ROW_W-1:0]   row_in;
   logic [ROW_W-1:0]   row_cur;
   logic [COUNT_W-1:0] row_sum;
   logic               row_last;

   logic               stage_valid_ff;
   logic               stage_valid_in;
   work_type           stage_ff;
   logic signed [ELEMENT_W-1:0] vector_rd_ff;

   always_comb begin
      rows = effective_count(cfg.row_count, COUNT_W'(MAX_ROWS));
      cols = effective_count(cfg.column_count, COUNT_W'(MAX_COLUMNS));

      req_ready   = !stage_valid_ff || push_ready;
      fire        = req_valid && req_ready;
      load_fire   = fire && (req_payload.mode == MODE_VECTOR);
      matrix_fire = fire && (req_payload.mode == MODE_MATRIX);

      // A counter left at or beyond a reduced count starts again from zero.
      load_cur = (COUNT_W'(load_ff) >= cols) ? '0 : load_ff;
      load_sum = COUNT_W'(load_cur) + 1'b1;
      col_cur  = (COUNT_W'(col_ff) >= cols) ? '0 : col_ff;
      col_sum  = COUNT_W'(col_cur) + 1'b1;
      col_last = (col_sum >= cols);
      row_cur  = (COUNT_W'(row_ff) >= rows) ? '0 : row_ff;
      row_sum  = COUNT_W'(row_cur) + 1'b1;
      row_last = (row_sum >= rows);

      load_in = load_ff;
      if (load_fire) begin
         load_in = (load_sum >= cols) ? '0 : COL_W'(load_sum);
      end

      col_in = col_ff;
      row_in = row_ff;
      if (matrix_fire) begin
         col_in = col_last ? '0 : COL_W'(col_sum);
         row_in = row_cur;
         if (col_last) begin
            row_in = row_last ? '0 : ROW_W'(row_sum);
         end
      end

      stage_valid_in = matrix_fire || (stage_valid_ff && !push_ready);

      push_valid   = stage_valid_ff;
      push_data    = stage_ff;
      push_data.vector_value = vector_rd_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         load_ff        <= '0;
         col_ff         <= '0;
         row_ff         <= '0;
         stage_valid_ff <= 1'b0;
      end else begin
         load_ff        <= load_in;
         col_ff         <= col_in;
         row_ff         <= row_in;
         stage_valid_ff <= stage_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (load_fire) begin
         vector_store[load_cur] <= req_payload.element_value;
      end
      if (matrix_fire) begin
         vector_rd_ff <= vector_store[col_cur];
      end
   end

   always_ff @(posedge clock) begin
      if (matrix_fire) begin
         stage_ff.element_value <= req_payload.element_value;
         stage_ff.vector_value  <= '0;
         stage_ff.last_column   <= col_last;
         stage_ff.row_index     <= ROW_INDEX_W'(row_cur);
         stage_ff.last_row      <= row_last;
      end
   end

endmodule

// ===== design/mvp_queue.sv =====
`timescale 1ns / 1ps

module mvp_queue (
   input  logic              clock,
   input  logic              reset,
   input  logic              push_valid,
   output logic              push_ready,
   input  mvp_pkg::work_type push_data,
   output logic              pop_valid,
   input  logic              pop_ready,
   output mvp_pkg::work_type pop_data
);
   import mvp_pkg::*;

   localparam int PTR_W   = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int COUNT_QW = $clog2(QUEUE_DEPTH + 1);

   work_type             entry_ff [QUEUE_DEPTH];
   logic [PTR_W-1:0]     wr_ptr_ff;
   logic [PTR_W-1:0]     wr_ptr_in;
   logic [PTR_W-1:0]     rd_ptr_ff;
   logic [PTR_W-1:0]     rd_ptr_in;
   logic [COUNT_QW-1:0]  fill_ff;
   logic [COUNT_QW-1:0]  fill_in;
   logic                 push_fire;
   logic                 pop_fire;

   always_comb begin
      push_ready = (fill_ff != COUNT_QW'(QUEUE_DEPTH));
      pop_valid  = (fill_ff != '0);
      pop_data   = entry_ff[rd_ptr_ff];
      push_fire  = push_valid && push_ready;
      pop_fire   = pop_valid && pop_ready;

      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      fill_in   = fill_ff;
      if (push_fire) begin
         wr_ptr_in = (wr_ptr_ff == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop_fire) begin
         rd_ptr_in = (rd_ptr_ff == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push_fire && !pop_fire) begin
         fill_in = fill_ff + 1'b1;
      end else if (pop_fire && !push_fire) begin
         fill_in = fill_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         fill_ff   <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         fill_ff   <= fill_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push_fire) begin
         entry_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

// ===== design/mvp_back.sv =====
`timescale 1ns / 1ps

module mvp_back (
   input  logic              clock,
   input  logic              reset,
   input  logic              pop_valid,
   output logic              pop_ready,
   input  mvp_pkg::work_type pop_data,
   output logic              rsp_valid,
   input  logic              rsp_ready,
   output mvp_pkg::rsp_type  rsp_payload
);
   import mvp_pkg::*;

   logic                        mul_valid_ff;
   logic                        mul_valid_in;
   logic signed [PRODUCT_W-1:0] product_ff;
   logic                        last_column_ff;
   logic [ROW_INDEX_W-1:0]      row_index_ff;
   logic                        last_row_ff;

   logic signed [SUM_W-1:0]     acc_ff;
   logic signed [SUM_W-1:0]     acc_in;
   logic signed [SUM_W-1:0]     acc_sum;

   logic                        rsp_valid_ff;
   logic                        rsp_valid_in;
   rsp_type                     rsp_ff;
   logic                        advance;

   always_comb begin
      advance      = !rsp_valid_ff || rsp_ready;
      pop_ready    = !mul_valid_ff || advance;
      mul_valid_in = pop_ready ? pop_valid : mul_valid_ff;

      // The sum wraps at its full width, which the input ranges never reach.
      acc_sum = acc_ff + SUM_W'(product_ff);

      acc_in       = acc_ff;
      rsp_valid_in = rsp_valid_ff;
      if (advance) begin
         rsp_valid_in = mul_valid_ff && last_column_ff;
         if (mul_valid_ff) begin
            acc_in = last_column_ff ? '0 : acc_sum;
         end
      end

      rsp_valid   = rsp_valid_ff;
      rsp_payload = rsp_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         mul_valid_ff <= 1'b0;
         acc_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         mul_valid_ff <= mul_valid_in;
         acc_ff       <= acc_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (pop_ready && pop_valid) begin
         product_ff     <= pop_data.element_value * pop_data.vector_value;
         last_column_ff <= pop_data.last_column;
         row_index_ff   <= pop_data.row_index;
         last_row_ff    <= pop_data.last_row;
      end
      if (advance && mul_valid_ff && last_column_ff) begin
         rsp_ff.row_sum   <= acc_sum;
         rsp_ff.row_index <= row_index_ff;
         rsp_ff.last_row  <= last_row_ff;
      end
   end

endmodule

// ===== tb/tb_matrix_vector_product.sv =====
`timescale 1ns / 1ps

module tb_matrix_vector_product;
   import mvp_pkg::*;

   localparam int unsigned SETTLE_CYCLES = 12;
   localparam int unsigned LONG_HOLD     = 80;
   localparam int unsigned STALL_LIMIT   = 2000;
   localparam int unsigned RANDOM_ITEMS  = 1300;
   localparam int unsigned CALM_FROM     = 1150;
   localparam logic [CSR_INDEX_W-1:0] CSR_UNMAPPED = CSR_INDEX_W'(3);

   logic                   clock = 1'b0;
   logic                   reset = 1'b1;
   logic                   req_valid = 1'b0;
   logic                   req_ready;
   req_type                req_payload = '0;
   logic                   rsp_valid;
   logic                   rsp_ready = 1'b0;
   rsp_type                rsp_payload;
   logic                   csr_write_enable = 1'b0;
   logic [CSR_INDEX_W-1:0] csr_index = '0;
   logic [CSR_DATA_W-1:0]  csr_write_data = '0;

   // Shadow of the block: configuration, vector store, counters and running row sum.
   logic [CSR_DATA_W-1:0]   rows_reg = RESET_ROW_COUNT;
   logic [CSR_DATA_W-1:0]   cols_reg = RESET_COLUMN_COUNT;
   logic signed [ELEMENT_W-1:0] vector_mem [DEF_MAX_COLUMNS] = '{default: '0};
   int unsigned             load_pos = 0;
   int unsigned             row_pos = 0;
   int unsigned             col_pos = 0;
   logic signed [SUM_W-1:0] row_total = '0;

   req_type     element_queue [$];
   rsp_type     row_sums_due [$];
   rsp_type     due_sum;
   int unsigned items_queued = 0;
   int unsigned failures = 0;
   int unsigned gap_left = 0;
   int unsigned hold_left = 0;
   int unsigned holds_requested = 0;
   int unsigned holds_done = 0;
   int unsigned stalled_cycles = 0;
   bit          calm = 1'b0;
   bit          sender_jitter = 1'b1;
   bit          receiver_jitter = 1'b1;

   matrix_vector_product uut (
      .clock            (clock),
      .reset            (reset),
      .req_valid        (req_valid),
      .req_ready        (req_ready),
      .req_payload      (req_payload),
      .rsp_valid        (rsp_valid),
      .rsp_ready        (rsp_ready),
      .rsp_payload      (rsp_payload),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data)
   );

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   function automatic int unsigned usable_count(input logic [CSR_DATA_W-1:0] raw,
                                                input int unsigned limit);
      if (raw == '0) begin
         return 1;
      end
      if (int'(raw) > limit) begin
         return limit;
      end
      return int'(raw);
   endfunction

   task automatic apply_element(input req_type item);
      int unsigned               rows;
      int unsigned               cols;
      logic signed [PRODUCT_W-1:0] product;
      rsp_type                   sum;
      rows = usable_count(rows_reg, DEF_MAX_ROWS);
      cols = usable_count(cols_reg, DEF_MAX_COLUMNS);
      if (item.mode == MODE_VECTOR) begin
         if (load_pos >= cols) begin
            load_pos = 0;
         end
         vector_mem[load_pos] = item.element_value;
         load_pos++;
         if (load_pos >= cols) begin
            load_pos = 0;
         end
      end else begin
         // A counter left at or beyond a reduced count wraps here, but the partial sum is kept.
         if (col_pos >= cols) begin
            col_pos = 0;
         end
         if (row_pos >= rows) begin
            row_pos = 0;
         end
         product = item.element_value * vector_mem[col_pos];
         row_total = row_total + product;
         col_pos++;
         if (col_pos >= cols) begin
            sum.row_sum = row_total;
            sum.row_index = ROW_INDEX_W'(row_pos);
            sum.last_row = (row_pos + 1 >= rows);
            row_sums_due.push_back(sum);
            row_total = '0;
            col_pos = 0;
            row_pos++;
            if (row_pos >= rows) begin
               row_pos = 0;
            end
         end
      end
   endtask

   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
      end else if (!req_valid || req_ready) begin
         if (req_valid) begin
            apply_element(req_payload);
         end
         if (gap_left != 0) begin
            gap_left--;
            req_valid <= 1'b0;
         end else if (!calm && sender_jitter && element_queue.size() != 0
                      && $urandom_range(0, 5) == 0) begin
            gap_left = $urandom_range(0, 5);
            req_valid <= 1'b0;
         end else if (element_queue.size() != 0) begin
            req_payload <= element_queue.pop_front();
            req_valid <= 1'b1;
         end else begin
            req_valid <= 1'b0;
         end
      end
   end

   always @(posedge clock) begin
      if (reset) begin
         rsp_ready <= 1'b0;
      end else begin
         if (rsp_valid && rsp_ready) begin
            if (row_sums_due.size() == 0) begin
               $error("unexpected result: row_sum %0d, row_index %0d, last_row %0b",
                      rsp_payload.row_sum, rsp_payload.row_index, rsp_payload.last_row);
               failures++;
            end else begin
               due_sum = row_sums_due.pop_front();
               if (rsp_payload.row_sum !== due_sum.row_sum) begin
                  $error("row_sum: expected %0d, got %0d", due_sum.row_sum,
                         rsp_payload.row_sum);
                  failures++;
               end
               if (rsp_payload.row_index !== due_sum.row_index) begin
                  $error("row_index: expected %0d, got %0d", due_sum.row_index,
                         rsp_payload.row_index);
                  failures++;
               end
               if (rsp_payload.last_row !== due_sum.last_row) begin
                  $error("last_row: expected %0b, got %0b", due_sum.last_row,
                         rsp_payload.last_row);
                  failures++;
               end
            end
         end
         if (holds_done != holds_requested) begin
            holds_done++;
            hold_left = LONG_HOLD;
         end
         if (hold_left != 0) begin
            hold_left--;
            rsp_ready <= 1'b0;
         end else if (!calm && receiver_jitter && $urandom_range(0, 4) == 0) begin
            hold_left = $urandom_range(0, 5);
            rsp_ready <= 1'b0;
         end else begin
            rsp_ready <= 1'b1;
         end
      end
   end

   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
         stalled_cycles = 0;
      end else begin
         stalled_cycles++;
         if (stalled_cycles >= STALL_LIMIT) begin
            $display("simulation failed");
            $finish;
         end
      end
   end

   function automatic logic signed [ELEMENT_W-1:0] pick_element();
      case ($urandom_range(0, 9))
         0: return 16'sh8000;
         1: return 16'sh7FFF;
         2: return '0;
         3: return -16'sd1;
         default: return ELEMENT_W'($urandom);
      endcase
   endfunction

   function automatic logic [CSR_DATA_W-1:0] pick_count();
      case ($urandom_range(0, 9))
         0: return '0;
         1: return CSR_DATA_W'(1);
         2: return CSR_DATA_W'(16);
         3: return CSR_DATA_W'($urandom_range(17, 31));
         4, 5: return CSR_DATA_W'($urandom_range(1, 16));
         default: return CSR_DATA_W'($urandom_range(1, 4));
      endcase
   endfunction

   task automatic queue_item(input logic mode, input logic signed [ELEMENT_W-1:0] value);
      req_type item;
      item.mode = mode;
      item.element_value = value;
      element_queue.push_back(item);
      items_queued++;
   endtask

   // Loading as many elements as there are columns in use fills every store entry in use,
   // wherever the load index happens to stand.
   task automatic queue_vector();
      repeat (usable_count(cols_reg, DEF_MAX_COLUMNS)) begin
         queue_item(MODE_VECTOR, pick_element());
      end
   endtask

   task automatic queue_matrix(input int unsigned count);
      repeat (count) begin
         queue_item(MODE_MATRIX, pick_element());
      end
   endtask

   task automatic drain_and_settle();
      while (element_queue.size() != 0 || req_valid || row_sums_due.size() != 0) begin
         @(posedge clock);
      end
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   task automatic write_register(input logic [CSR_INDEX_W-1:0] idx,
                                 input logic [CSR_DATA_W-1:0] value);
      @(posedge clock);
      csr_write_enable <= 1'b1;
      csr_index <= idx;
      csr_write_data <= value;
      @(posedge clock);
      csr_write_enable <= 1'b0;
      if (idx == CSR_ROW_COUNT) begin
         rows_reg = value;
      end else if (idx == CSR_COLUMN_COUNT) begin
         cols_reg = value;
      end
   endtask

   initial begin
      int unsigned elements;
      repeat (7) @(posedge clock);
      reset <= 1'b0;

      // Reset counts, extreme products, and a second row left half done.
      queue_item(MODE_VECTOR, 16'sh8000);
      queue_item(MODE_VECTOR, 16'sh7FFF);
      queue_item(MODE_VECTOR, -16'sd1);
      queue_item(MODE_VECTOR, 16'sd1);
      queue_item(MODE_MATRIX, 16'sh8000);
      queue_item(MODE_MATRIX, 16'sh8000);
      queue_item(MODE_MATRIX, 16'sh7FFF);
      queue_item(MODE_MATRIX, 16'sh8000);
      queue_item(MODE_MATRIX, 16'sh7FFF);
      queue_item(MODE_MATRIX, 16'sh7FFF);
      drain_and_settle();

      // Zero counts act as one; the half-done row wraps and keeps its partial sum.
      write_register(CSR_UNMAPPED, '1);
      write_register(CSR_ROW_COUNT, '0);
      write_register(CSR_COLUMN_COUNT, '0);
      queue_item(MODE_VECTOR, 16'sh4000);
      queue_item(MODE_MATRIX, 16'sh8000);
      queue_item(MODE_MATRIX, 16'sh7FFF);
      drain_and_settle();

      // An oversized row count, and a vector load in the middle of a row.
      write_register(CSR_ROW_COUNT, CSR_DATA_W'(20));
      write_register(CSR_COLUMN_COUNT, CSR_DATA_W'(3));
      queue_matrix(2);
      queue_vector();
      queue_matrix(4);
      drain_and_settle();

      // The receiver holds off while a result is due for every item.
      write_register(CSR_ROW_COUNT, CSR_DATA_W'(16));
      write_register(CSR_COLUMN_COUNT, CSR_DATA_W'(1));
      queue_vector();
      holds_requested++;
      queue_matrix(48);

      while (items_queued < RANDOM_ITEMS) begin
         drain_and_settle();
         if (items_queued >= CALM_FROM) begin
            calm = 1'b1;
         end
         sender_jitter = ($urandom_range(0, 3) != 0);
         receiver_jitter = ($urandom_range(0, 3) != 0);
         case ($urandom_range(0, 3))
            0: write_register(CSR_ROW_COUNT, pick_count());
            1: write_register(CSR_COLUMN_COUNT, pick_count());
            default: begin
               write_register(CSR_ROW_COUNT, pick_count());
               write_register(CSR_COLUMN_COUNT, pick_count());
            end
         endcase
         if ($urandom_range(0, 9) == 0) begin
            write_register(CSR_UNMAPPED, CSR_DATA_W'($urandom));
         end
         queue_vector();
         if (!calm && $urandom_range(0, 5) == 0) begin
            holds_requested++;
         end
         elements = usable_count(rows_reg, DEF_MAX_ROWS)
                    * usable_count(cols_reg, DEF_MAX_COLUMNS);
         repeat ($urandom_range(1, 4)) begin
            case ($urandom_range(0, 9))
               0: begin
                  repeat ($urandom_range(1, 8)) begin
                     queue_item(logic'($urandom_range(0, 1)), pick_element());
                  end
               end
               1: begin
                  queue_matrix($urandom_range(1, elements));
                  repeat ($urandom_range(1, usable_count(cols_reg, DEF_MAX_COLUMNS))) begin
                     queue_item(MODE_VECTOR, pick_element());
                  end
               end
               default: begin
                  if ($urandom_range(0, 1) == 0) begin
                     queue_vector();
                  end
                  queue_matrix(elements);
               end
            endcase
         end
      end

      drain_and_settle();
      if (failures == 0) begin
         $display("simulation ok");
      end else begin
         $display("simulation failed");
      end
      $finish;
   end

endmodule
